>>> rtl/core/gal_pkg.sv
// Shared types and constants for the global alignment engine.
package gal_pkg;

  localparam int MaxLen    = 32;
  localparam int Alphabet  = 26;
  localparam int LenW      = $clog2(MaxLen + 1);
  localparam int IdxW      = $clog2(MaxLen);
  localparam int LetterW   = 5;
  localparam int WeightW   = 8;
  localparam int ScoreW    = 14;
  localparam int CntW      = $clog2(2 * MaxLen + 1);

  localparam logic [LetterW-1:0] GapCode = LetterW'(26);

  typedef enum logic [1:0] {
    MODE_TABLE    = 2'd0,
    MODE_APPEND_A = 2'd1,
    MODE_APPEND_B = 2'd2,
    MODE_ALIGN    = 2'd3
  } gal_mode_e;

  typedef enum logic [1:0] {
    DIR_DIAG  = 2'd0,
    DIR_GAP_B = 2'd1,
    DIR_GAP_A = 2'd2
  } gal_dir_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_TRACE
  } gal_state_e;

  // Data handed from one cell to the next: one grid row of one column.
  typedef struct packed {
    logic                               valid;
    logic [LenW-1:0]                    row;
    logic [ScoreW-1:0]                  s;     // score of this row
    logic [ScoreW-1:0]                  p;     // score of the row above
    logic [Alphabet-1:0][WeightW-1:0]   wrow;  // table row of the A letter
  } gal_link_t;

endpackage

>>> rtl/core/gal_ram.sv
// Generic single-port RAM with registered read.
module gal_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/gal_cell.sv
// One column cell of the systolic score grid with its own direction column.
module gal_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  gal_pkg::gal_link_t                link_i,
  input  logic [gal_pkg::LetterW-1:0]       b_letter_i,
  input  logic [gal_pkg::WeightW-1:0]       gap_i,
  input  logic [gal_pkg::IdxW-1:0]          rd_row_i,
  output gal_pkg::gal_link_t                link_o,
  output gal_pkg::gal_dir_e                 dir_o
);

  logic                                  valid_q;
  logic [gal_pkg::LenW-1:0]              row_q;
  logic [gal_pkg::ScoreW-1:0]            s_q, s_d;
  logic [gal_pkg::ScoreW-1:0]            p_q;
  logic [gal_pkg::Alphabet-1:0][gal_pkg::WeightW-1:0] wrow_q;
  gal_pkg::gal_dir_e                     dir_q [gal_pkg::MaxLen];
  gal_pkg::gal_dir_e                     dir_d;

  logic [gal_pkg::WeightW-1:0]           weight;
  logic [gal_pkg::ScoreW:0]              cand_d, cand_b, cand_a, best;
  logic [gal_pkg::LenW-1:0]              row_m1;

  // substitution weight for this column's letter
  always_comb begin
    if (b_letter_i < gal_pkg::LetterW'(gal_pkg::Alphabet)) begin
      weight = link_i.wrow[b_letter_i];
    end else begin
      weight = '0;
    end
  end

  // min of three moves, ties favor diagonal, then gap in B, then gap in A
  always_comb begin
    cand_d = {1'b0, link_i.p} + (gal_pkg::ScoreW+1)'(weight);
    cand_b = {1'b0, s_q} + (gal_pkg::ScoreW+1)'(gap_i);
    cand_a = {1'b0, link_i.s} + (gal_pkg::ScoreW+1)'(gap_i);
    best   = cand_d;
    dir_d  = gal_pkg::DIR_DIAG;
    if (cand_b < best) begin
      best  = cand_b;
      dir_d = gal_pkg::DIR_GAP_B;
    end
    if (cand_a < best) begin
      best  = cand_a;
      dir_d = gal_pkg::DIR_GAP_A;
    end
    // top edge row: only the move from the left exists
    if (link_i.row == '0) begin
      s_d = cand_a[gal_pkg::ScoreW-1:0];
    end else begin
      s_d = best[gal_pkg::ScoreW-1:0];
    end
    row_m1 = link_i.row - gal_pkg::LenW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= link_i.valid;
    end
  end

  // score and pass-through registers
  always_ff @(posedge clk_i) begin
    if (link_i.valid) begin
      row_q  <= link_i.row;
      wrow_q <= link_i.wrow;
      p_q    <= s_q;
      s_q    <= s_d;
      if (link_i.row != '0) begin
        dir_q[row_m1[gal_pkg::IdxW-1:0]] <= dir_d;
      end
    end
  end

  assign link_o.valid = valid_q;
  assign link_o.row   = row_q;
  assign link_o.s     = s_q;
  assign link_o.p     = p_q;
  assign link_o.wrow  = wrow_q;
  assign dir_o        = dir_q[rd_row_i];

endmodule

>>> rtl/core/global_alignment_min_penalty.sv
// Top level: command decode, sequence stores, cell chain and traceback.
//
//  channel   | signals                        | content
//  ----------+--------------------------------+-------------------------------
//  s_axis    | tvalid tready tdata tuser      | table writes, appends, align
//  m_axis    | tvalid tready tdata tuser tlast| aligned pairs, last pair first
//  cfg       | cfg_we_i cfg_wdata_i           | gap penalty, reset value 2
//
// An align runs the score wavefront through the 32-cell chain, then returns
// the aligned pairs (at most 64), paced by m_axis_tready. Input is held off
// from align to the loading of the last pair. No clearing pass after reset;
// stores are written before they are read.
module global_alignment_min_penalty (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [4:0] row_letter, [9:5] col_letter, [17:10] weight, [22:18] symbol
  input  logic [23:0] s_axis_tdata,
  // [1:0] mode
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [4:0] a_out, [9:5] b_out, [23:10] penalty
  output logic [23:0] m_axis_tdata,
  // [0] pair_valid, [1] overflow
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i
);

  localparam int N = gal_pkg::MaxLen;

  gal_pkg::gal_state_e state_q, state_d;

  logic [gal_pkg::WeightW-1:0] gap_q;
  logic [gal_pkg::LenW-1:0]    len_a_q, len_b_q;
  logic                        drop_q;
  logic [gal_pkg::LetterW-1:0] seq_a_q [N];
  logic [gal_pkg::LetterW-1:0] seq_b_q [N];

  logic                        hvalid_q;
  logic [gal_pkg::LenW-1:0]    hr_q;
  logic [gal_pkg::ScoreW-1:0]  hs_q, hp_q;
  logic [gal_pkg::CntW-1:0]    cnt_q;
  logic [gal_pkg::ScoreW-1:0]  total_q;
  logic [gal_pkg::LenW-1:0]    i_q, j_q;

  logic                        out_valid_q;
  logic [gal_pkg::LetterW-1:0] out_a_q, out_b_q;
  logic [gal_pkg::ScoreW-1:0]  out_pen_q;
  logic                        out_pv_q, out_ovf_q, out_last_q;

  // input decode
  logic                        in_acc;
  gal_pkg::gal_mode_e          mode;
  logic [gal_pkg::LetterW-1:0] row_letter, col_letter, symbol;
  logic [gal_pkg::WeightW-1:0] weight;

  assign s_axis_tready = (state_q == gal_pkg::ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign mode          = gal_pkg::gal_mode_e'(s_axis_tuser);
  assign row_letter    = s_axis_tdata[4:0];
  assign col_letter    = s_axis_tdata[9:5];
  assign weight        = s_axis_tdata[17:10];
  assign symbol        = s_axis_tdata[22:18];

  logic fill_done, load, tb_last, app_a, app_b, drop_a, drop_b, tbl_we;
  logic [gal_pkg::CntW-1:0] len_sum;

  assign len_sum   = gal_pkg::CntW'(len_a_q) + gal_pkg::CntW'(len_b_q);
  assign fill_done = (state_q == gal_pkg::ST_FILL) && (cnt_q == len_sum);
  assign load      = (state_q == gal_pkg::ST_TRACE) && (!out_valid_q || m_axis_tready);

  assign app_a  = in_acc && (mode == gal_pkg::MODE_APPEND_A);
  assign app_b  = in_acc && (mode == gal_pkg::MODE_APPEND_B);
  assign drop_a = (len_a_q >= gal_pkg::LenW'(N)) ||
                  (symbol >= gal_pkg::LetterW'(gal_pkg::Alphabet));
  assign drop_b = (len_b_q >= gal_pkg::LenW'(N)) ||
                  (symbol >= gal_pkg::LetterW'(gal_pkg::Alphabet));
  assign tbl_we = in_acc && (mode == gal_pkg::MODE_TABLE) &&
                  (row_letter < gal_pkg::LetterW'(gal_pkg::Alphabet)) &&
                  (col_letter < gal_pkg::LetterW'(gal_pkg::Alphabet));

  // traceback step
  logic [gal_pkg::LenW-1:0]    im1, jm1, i_n, j_n;
  logic [gal_pkg::IdxW-1:0]    a_idx;
  logic [gal_pkg::LetterW-1:0] a_letter, b_letter, a_sel, b_sel;
  gal_pkg::gal_dir_e           dir_all [N];
  gal_pkg::gal_dir_e           dir;

  assign im1      = i_q - gal_pkg::LenW'(1);
  assign jm1      = j_q - gal_pkg::LenW'(1);
  assign a_idx    = (state_q == gal_pkg::ST_FILL) ? hr_q[gal_pkg::IdxW-1:0]
                                                  : im1[gal_pkg::IdxW-1:0];
  assign a_letter = seq_a_q[a_idx];
  assign b_letter = seq_b_q[jm1[gal_pkg::IdxW-1:0]];

  always_comb begin
    if (i_q != '0 && j_q != '0) begin
      dir = dir_all[jm1[gal_pkg::IdxW-1:0]];
    end else if (i_q != '0) begin
      dir = gal_pkg::DIR_GAP_B;
    end else begin
      dir = gal_pkg::DIR_GAP_A;
    end
    i_n   = i_q;
    j_n   = j_q;
    a_sel = gal_pkg::GapCode;
    b_sel = gal_pkg::GapCode;
    case (dir)
      gal_pkg::DIR_DIAG: begin
        a_sel = a_letter;
        b_sel = b_letter;
        i_n   = im1;
        j_n   = jm1;
      end
      gal_pkg::DIR_GAP_B: begin
        a_sel = a_letter;
        i_n   = im1;
      end
      default: begin
        b_sel = b_letter;
        j_n   = jm1;
      end
    endcase
    // both sequences empty: a single gap-gap result
    if (i_q == '0 && j_q == '0) begin
      b_sel = gal_pkg::GapCode;
      j_n   = j_q;
    end
  end

  // empty run, or this pair is the first one of the alignment
  assign tb_last = (i_q == '0 && j_q == '0) || (i_n == '0 && j_n == '0);

  // state machine
  always_comb begin
    state_d = state_q;
    case (state_q)
      gal_pkg::ST_IDLE: begin
        if (in_acc && mode == gal_pkg::MODE_ALIGN) begin
          state_d = gal_pkg::ST_FILL;
        end
      end
      gal_pkg::ST_FILL: begin
        if (fill_done) begin
          state_d = gal_pkg::ST_TRACE;
        end
      end
      gal_pkg::ST_TRACE: begin
        if (load && tb_last) begin
          state_d = gal_pkg::ST_IDLE;
        end
      end
      default: state_d = gal_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gal_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // config, lengths, drop flag, head valid and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q       <= gal_pkg::WeightW'(2);
      len_a_q     <= '0;
      len_b_q     <= '0;
      drop_q      <= 1'b0;
      hvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        gap_q <= cfg_wdata_i;
      end
      if (app_a) begin
        if (drop_a) begin
          drop_q <= 1'b1;
        end else begin
          len_a_q <= len_a_q + gal_pkg::LenW'(1);
        end
      end
      if (app_b) begin
        if (drop_b) begin
          drop_q <= 1'b1;
        end else begin
          len_b_q <= len_b_q + gal_pkg::LenW'(1);
        end
      end
      if (in_acc && mode == gal_pkg::MODE_ALIGN) begin
        hvalid_q <= 1'b1;
      end else if (hvalid_q && hr_q >= len_a_q) begin
        hvalid_q <= 1'b0;
      end
      if (load && tb_last) begin
        len_a_q <= '0;
        len_b_q <= '0;
        drop_q  <= 1'b0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // sequence stores
  always_ff @(posedge clk_i) begin
    if (app_a && !drop_a) begin
      seq_a_q[len_a_q[gal_pkg::IdxW-1:0]] <= symbol;
    end
    if (app_b && !drop_b) begin
      seq_b_q[len_b_q[gal_pkg::IdxW-1:0]] <= symbol;
    end
  end

  // head of the chain: left edge column, one row per cycle
  always_ff @(posedge clk_i) begin
    if (in_acc && mode == gal_pkg::MODE_ALIGN) begin
      hr_q  <= '0;
      hs_q  <= '0;
      hp_q  <= '0;
      cnt_q <= '0;
    end else if (state_q == gal_pkg::ST_FILL) begin
      cnt_q <= cnt_q + gal_pkg::CntW'(1);
      if (hvalid_q && hr_q < len_a_q) begin
        hr_q <= hr_q + gal_pkg::LenW'(1);
        hp_q <= hs_q;
        hs_q <= hs_q + gal_pkg::ScoreW'(gap_q);
      end
    end
  end

  // table banks, one per column letter; a full row is read per cycle
  logic [gal_pkg::Alphabet-1:0][gal_pkg::WeightW-1:0] tbl_row;
  logic [gal_pkg::LetterW-1:0] tbl_addr;

  assign tbl_addr = (state_q == gal_pkg::ST_FILL) ? a_letter : row_letter;

  for (genvar c = 0; c < gal_pkg::Alphabet; c++) begin : g_bank
    gal_ram #(
      .Width (gal_pkg::WeightW),
      .Depth (gal_pkg::Alphabet)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (tbl_we && (col_letter == gal_pkg::LetterW'(c))),
      .addr_i  (tbl_addr),
      .wdata_i (weight),
      .rdata_o (tbl_row[c])
    );
  end

  // cell chain
  gal_pkg::gal_link_t links [N+1];

  assign links[0].valid = hvalid_q;
  assign links[0].row   = hr_q;
  assign links[0].s     = hs_q;
  assign links[0].p     = hp_q;
  assign links[0].wrow  = tbl_row;

  for (genvar k = 0; k < N; k++) begin : g_cell
    gal_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .link_i     (links[k]),
      .b_letter_i (seq_b_q[k]),
      .gap_i      (gap_q),
      .rd_row_i   (im1[gal_pkg::IdxW-1:0]),
      .link_o     (links[k+1]),
      .dir_o      (dir_all[k])
    );
  end

  // traceback counters and total
  always_ff @(posedge clk_i) begin
    if (fill_done) begin
      total_q <= links[len_b_q].s;
      i_q     <= len_a_q;
      j_q     <= len_b_q;
    end else if (load) begin
      i_q <= i_n;
      j_q <= j_n;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_a_q    <= a_sel;
      out_b_q    <= b_sel;
      out_pv_q   <= (i_q != '0) || (j_q != '0);
      out_pen_q  <= tb_last ? total_q : '0;
      out_ovf_q  <= drop_q;
      out_last_q <= tb_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_pen_q, out_b_q, out_a_q};
  assign m_axis_tuser  = {out_ovf_q, out_pv_q};
  assign m_axis_tlast  = out_last_q;

  // traceback never walks outside the filled grid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gal_pkg::ST_TRACE) |-> (i_q <= len_a_q) && (j_q <= len_b_q))
    else $error("traceback index beyond sequence length");

  // the fill counter stops at the end of the wavefront
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gal_pkg::ST_FILL) |-> (cnt_q <= len_sum))
    else $error("fill counter ran past the wavefront");

  // loading the final pair returns to idle with the sequence lengths cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && tb_last) |=> (state_q == gal_pkg::ST_IDLE) && (len_a_q == '0) &&
                          (len_b_q == '0) && out_valid_q && m_axis_tlast)
    else $error("alignment run did not close cleanly");

  // head never runs ahead of sequence A
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hvalid_q |-> (hr_q <= len_a_q))
    else $error("head row beyond sequence A");

endmodule
